// ===== rtl/core/dll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_pkg: shared types and constants of the doubly linked list store
// Pool size, field widths, request and status codes, sequencer states, memory port structs.
// ----------------------------------------------------------------------------
package dll_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int KIND_W      = 4;
    localparam int STATUS_W    = 2;

    localparam logic [IDX_W-1:0] NODE_NONE = IDX_W'(CAPACITY);

    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_READ       = 4'd5;
    localparam logic [KIND_W-1:0] KIND_WRITE      = 4'd6;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ERASE      = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_WALK_WT,
        S_ACC,
        S_ACC_WT,
        S_TAKE,
        S_TAKE_WT,
        S_LNK_PREV,
        S_LNK_PREV_WT,
        S_LNK_W1,
        S_LNK_W2,
        S_LNK_W3,
        S_UNL_RD,
        S_UNL_WT,
        S_UNL_W1,
        S_UNL_W2,
        S_UNL_W3,
        S_FIN,
        S_FIN_F,
        S_FIN_B
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]      addr;
        logic                   we_value;
        logic                   we_next;
        logic                   we_prev;
        logic [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]       next;
        logic [IDX_W-1:0]       prev;
    } t_ram_wr;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]       next;
        logic [IDX_W-1:0]       prev;
    } t_ram_rd;

    function automatic logic node_ok(input logic [IDX_W-1:0] n);
        return n < NODE_NONE;
    endfunction

endpackage

// ===== rtl/core/dll_node_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_node_ram: node pool memory
// Value, next link and prev link per node; one write, one registered read.
// ----------------------------------------------------------------------------
module dll_node_ram
    import dll_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_ram_rd           o_rd
);

    logic [VALUE_WIDTH-1:0] r_value [CAPACITY];
    logic [IDX_W-1:0]       r_next  [CAPACITY];
    logic [IDX_W-1:0]       r_prev  [CAPACITY];
    t_ram_rd                r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_value) begin
            r_value[i_wr.addr] <= i_wr.value;
        end
        if (i_wr.we_next) begin
            r_next[i_wr.addr] <= i_wr.next;
        end
        if (i_wr.we_prev) begin
            r_prev[i_wr.addr] <= i_wr.prev;
        end
        r_rd.value <= r_value[i_raddr];
        r_rd.next  <= r_next[i_raddr];
        r_rd.prev  <= r_prev[i_raddr];
    end

    assign o_rd = r_rd;

endmodule

// ===== rtl/core/doubly_linked_list_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_store: bounded sequence of signed words in a node pool
// Push/pop at either end, clear, positional read/write/insert/erase.
// ----------------------------------------------------------------------------
// Input channel i_in_valid/o_in_ready carries one request word (kind,
// position, value). Output channel o_out_valid/i_out_ready returns one
// result word per request: value read or removed, entry count, front and
// back values, status.
// A single sequencer drives one node memory port (one write and one
// registered read per cycle). Clear, unused kinds and any request that
// fails go from the decision straight to the finish steps; push and insert
// at the end take and link a node, pop unlinks one. Read, write, insert and
// erase at position p first walk the links from the front, one node at a
// time. One request is in work at a time; the input is ready again in the
// cycle after the result is loaded.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds the sequencer at its last step until the
// register frees up.
// Reset empties the store at once; node memory needs no clearing pass.
// ----------------------------------------------------------------------------
module doubly_linked_list_store
    import dll_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [KIND_W-1:0]             i_kind,
    input  logic [IDX_W-1:0]              i_position,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [VALUE_WIDTH-1:0] o_read_value,
    output logic [IDX_W-1:0]              o_entry_count,
    output logic signed [VALUE_WIDTH-1:0] o_front_value,
    output logic signed [VALUE_WIDTH-1:0] o_back_value,
    output logic [STATUS_W-1:0]           o_status
);

    t_state r_state, n_state;

    logic [KIND_W-1:0]      r_kind;
    logic [IDX_W-1:0]       r_pos;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [IDX_W-1:0]       r_cur, n_cur;
    logic [IDX_W-1:0]       r_node, n_node;
    logic [IDX_W-1:0]       r_p, n_p;
    logic [IDX_W-1:0]       r_q, n_q;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_first, n_first;
    logic [IDX_W-1:0]       r_last, n_last;
    logic [IDX_W-1:0]       r_free, n_free;
    logic [IDX_W-1:0]       r_nu, n_nu;
    logic [IDX_W-1:0]       r_count, n_count;
    logic [VALUE_WIDTH-1:0] r_rd, n_rd;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_front, n_front;

    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_o_rd, r_o_front, r_o_back;
    logic [IDX_W-1:0]       r_o_count;
    logic [STATUS_W-1:0]    r_o_status;

    t_ram_wr           ram_wr;
    t_ram_rd           ram_rd;
    logic [ADDR_W-1:0] ram_raddr;

    logic full, empty, accept, load;

    assign full   = r_count == NODE_NONE;
    assign empty  = r_count == '0;
    assign accept = i_in_valid && o_in_ready;
    assign load   = (r_state == S_FIN_B) && (!r_out_valid || i_out_ready);

    dll_node_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_raddr (ram_raddr),
        .o_rd    (ram_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                case (r_kind)
                    KIND_PUSH_BACK, KIND_PUSH_FRONT:
                        n_state = full ? S_FIN : S_TAKE;
                    KIND_POP_BACK, KIND_POP_FRONT:
                        n_state = empty ? S_FIN : S_UNL_RD;
                    KIND_READ, KIND_WRITE, KIND_ERASE:
                        n_state = (r_pos >= r_count) ? S_FIN : S_WALK;
                    KIND_INSERT: begin
                        if (full || r_pos > r_count) n_state = S_FIN;
                        else if (r_pos == r_count)   n_state = S_TAKE;
                        else                         n_state = S_WALK;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_WALK: begin
                if (r_idx != r_pos)              n_state = S_WALK_WT;
                else if (r_kind == KIND_INSERT)  n_state = S_TAKE;
                else if (r_kind == KIND_ERASE)   n_state = S_UNL_RD;
                else                             n_state = S_ACC;
            end
            S_WALK_WT:     n_state = S_WALK;
            S_ACC:         n_state = (r_kind == KIND_READ) ? S_ACC_WT : S_FIN;
            S_ACC_WT:      n_state = S_FIN;
            S_TAKE:        n_state = node_ok(r_free) ? S_TAKE_WT : S_LNK_PREV;
            S_TAKE_WT:     n_state = S_LNK_PREV;
            S_LNK_PREV:    n_state = node_ok(r_cur) ? S_LNK_PREV_WT : S_LNK_W1;
            S_LNK_PREV_WT: n_state = S_LNK_W1;
            S_LNK_W1:      n_state = S_LNK_W2;
            S_LNK_W2:      n_state = S_LNK_W3;
            S_LNK_W3:      n_state = S_FIN;
            S_UNL_RD:      n_state = S_UNL_WT;
            S_UNL_WT:      n_state = S_UNL_W1;
            S_UNL_W1:      n_state = S_UNL_W2;
            S_UNL_W2:      n_state = S_UNL_W3;
            S_UNL_W3:      n_state = S_FIN;
            S_FIN:         n_state = S_FIN_F;
            S_FIN_F:       n_state = S_FIN_B;
            S_FIN_B: begin
                if (load) n_state = S_IDLE;
            end
            default:       n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cur    = r_cur;
        n_node   = r_node;
        n_p      = r_p;
        n_q      = r_q;
        n_idx    = r_idx;
        n_first  = r_first;
        n_last   = r_last;
        n_free   = r_free;
        n_nu     = r_nu;
        n_count  = r_count;
        n_rd     = r_rd;
        n_status = r_status;
        n_front  = r_front;
        ram_wr   = '0;
        ram_raddr = r_cur[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: ;
            S_DECIDE: begin
                n_rd     = '0;
                n_status = ST_OK;
                n_idx    = '0;
                n_cur    = r_first;
                case (r_kind)
                    KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                        if (full) n_status = ST_FULL;
                        if (r_kind == KIND_PUSH_BACK) n_cur = NODE_NONE;
                    end
                    KIND_POP_BACK, KIND_POP_FRONT: begin
                        if (empty) n_status = ST_EMPTY;
                        if (r_kind == KIND_POP_BACK) n_cur = r_last;
                    end
                    KIND_CLEAR: begin
                        n_first = NODE_NONE;
                        n_last  = NODE_NONE;
                        n_free  = NODE_NONE;
                        n_nu    = '0;
                        n_count = '0;
                    end
                    KIND_READ, KIND_WRITE: begin
                        if (r_pos >= r_count) n_status = ST_RANGE;
                    end
                    KIND_INSERT: begin
                        if (full)                  n_status = ST_FULL;
                        else if (r_pos > r_count)  n_status = ST_RANGE;
                        if (r_pos == r_count)      n_cur = NODE_NONE;
                    end
                    KIND_ERASE: begin
                        if (empty)                  n_status = ST_EMPTY;
                        else if (r_pos >= r_count)  n_status = ST_RANGE;
                    end
                    default: ;
                endcase
            end
            S_WALK: ;
            S_WALK_WT: begin
                n_cur = ram_rd.next;
                n_idx = r_idx + 1'b1;
            end
            S_ACC: begin
                if (r_kind == KIND_WRITE) begin
                    ram_wr.addr     = r_cur[ADDR_W-1:0];
                    ram_wr.we_value = 1'b1;
                    ram_wr.value    = r_val;
                end
            end
            S_ACC_WT: n_rd = ram_rd.value;
            S_TAKE: begin
                ram_raddr = r_free[ADDR_W-1:0];
                if (!node_ok(r_free)) begin
                    n_node = r_nu;
                    n_nu   = r_nu + 1'b1;
                end
            end
            S_TAKE_WT: begin
                n_node = r_free;
                n_free = ram_rd.next;
            end
            S_LNK_PREV: begin
                if (!node_ok(r_cur)) n_p = r_last;
            end
            S_LNK_PREV_WT: n_p = ram_rd.prev;
            S_LNK_W1: begin
                ram_wr.addr     = r_node[ADDR_W-1:0];
                ram_wr.we_value = 1'b1;
                ram_wr.we_next  = 1'b1;
                ram_wr.we_prev  = 1'b1;
                ram_wr.value    = r_val;
                ram_wr.next     = r_cur;
                ram_wr.prev     = r_p;
            end
            S_LNK_W2: begin
                if (node_ok(r_p)) begin
                    ram_wr.addr    = r_p[ADDR_W-1:0];
                    ram_wr.we_next = 1'b1;
                    ram_wr.next    = r_node;
                end else begin
                    n_first = r_node;
                end
            end
            S_LNK_W3: begin
                if (node_ok(r_cur)) begin
                    ram_wr.addr    = r_cur[ADDR_W-1:0];
                    ram_wr.we_prev = 1'b1;
                    ram_wr.prev    = r_node;
                end else begin
                    n_last = r_node;
                end
                n_count = r_count + 1'b1;
            end
            S_UNL_RD: ;
            S_UNL_WT: begin
                n_p  = ram_rd.prev;
                n_q  = ram_rd.next;
                n_rd = ram_rd.value;
            end
            S_UNL_W1: begin
                if (node_ok(r_p)) begin
                    ram_wr.addr    = r_p[ADDR_W-1:0];
                    ram_wr.we_next = 1'b1;
                    ram_wr.next    = r_q;
                end else begin
                    n_first = r_q;
                end
            end
            S_UNL_W2: begin
                if (node_ok(r_q)) begin
                    ram_wr.addr    = r_q[ADDR_W-1:0];
                    ram_wr.we_prev = 1'b1;
                    ram_wr.prev    = r_p;
                end else begin
                    n_last = r_p;
                end
            end
            S_UNL_W3: begin
                ram_wr.addr    = r_cur[ADDR_W-1:0];
                ram_wr.we_next = 1'b1;
                ram_wr.next    = r_free;
                n_free         = r_cur;
                n_count        = r_count - 1'b1;
            end
            S_FIN: ram_raddr = r_first[ADDR_W-1:0];
            S_FIN_F: begin
                ram_raddr = r_last[ADDR_W-1:0];
                n_front   = node_ok(r_first) ? ram_rd.value : '0;
            end
            S_FIN_B: ram_raddr = r_last[ADDR_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= NODE_NONE;
            r_last      <= NODE_NONE;
            r_free      <= NODE_NONE;
            r_nu        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_last      <= n_last;
            r_free      <= n_free;
            r_nu        <= n_nu;
            r_count     <= n_count;
            r_out_valid <= load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        r_cur    <= n_cur;
        r_node   <= n_node;
        r_p      <= n_p;
        r_q      <= n_q;
        r_idx    <= n_idx;
        r_rd     <= n_rd;
        r_status <= n_status;
        r_front  <= n_front;
        if (load) begin
            r_o_rd     <= r_rd;
            r_o_count  <= r_count;
            r_o_front  <= r_front;
            r_o_back   <= node_ok(r_last) ? ram_rd.value : '0;
            r_o_status <= r_status;
        end
    end

    assign o_in_ready    = r_state == S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_o_rd;
    assign o_entry_count = r_o_count;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_status      = r_o_status;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NODE_NONE)
        else $error("entry count above capacity");

    a_empty_links: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0)
            |-> (r_first == NODE_NONE && r_last == NODE_NONE))
        else $error("empty store with live end links");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(ram_wr.we_value || ram_wr.we_next || ram_wr.we_prev))
        else $error("node write while idle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DECIDE) |=> (r_count == $past(r_count)
            || r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the doubly linked list store
// Drives request words through the valid/ready input, predicts each result
// with a queue of values, and checks every result word field by field.
// Covers directed corner rows, fill-to-full runs, random traffic, bursty
// input, receiver stalls, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import dll_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int RAND_WORDS  = 640;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] rd;
        logic [IDX_W-1:0]              cnt;
        logic signed [VALUE_WIDTH-1:0] front;
        logic signed [VALUE_WIDTH-1:0] back;
        logic [STATUS_W-1:0]           st;
    } t_result;

    typedef struct {
        logic [KIND_W-1:0]             kind;
        logic [IDX_W-1:0]              pos;
        logic signed [VALUE_WIDTH-1:0] val;
        bit                            typed;
        logic [STATUS_W-1:0]           st;
        logic [IDX_W-1:0]              cnt;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [KIND_W-1:0]             i_kind = '0;
    logic [IDX_W-1:0]              i_position = '0;
    logic signed [VALUE_WIDTH-1:0] i_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [VALUE_WIDTH-1:0] o_read_value;
    logic [IDX_W-1:0]              o_entry_count;
    logic signed [VALUE_WIDTH-1:0] o_front_value;
    logic signed [VALUE_WIDTH-1:0] o_back_value;
    logic [STATUS_W-1:0]           o_status;

    logic signed [VALUE_WIDTH-1:0] list_vals[$];
    t_result                       pending_results[$];
    int mismatches = 0;
    int words_in = 0;
    int words_out = 0;
    int full_hits = 0;
    int range_hits = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    doubly_linked_list_store u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_status      (o_status)
    );

    function automatic t_result apply_request(input logic [KIND_W-1:0] kind,
                                              input logic [IDX_W-1:0] pos,
                                              input logic signed [VALUE_WIDTH-1:0] val);
        t_result r;
        int      size;
        bit      full;
        r = '0;
        r.st = ST_OK;
        size = list_vals.size();
        full = size >= CAPACITY;
        case (kind)
            KIND_PUSH_BACK: begin
                if (full) r.st = ST_FULL;
                else list_vals.insert(size, val);
            end
            KIND_PUSH_FRONT: begin
                if (full) r.st = ST_FULL;
                else list_vals.insert(0, val);
            end
            KIND_POP_BACK: begin
                if (size == 0) r.st = ST_EMPTY;
                else begin
                    r.rd = list_vals[size-1];
                    list_vals.delete(size-1);
                end
            end
            KIND_POP_FRONT: begin
                if (size == 0) r.st = ST_EMPTY;
                else begin
                    r.rd = list_vals[0];
                    list_vals.delete(0);
                end
            end
            KIND_CLEAR: list_vals.delete();
            KIND_READ: begin
                if (int'(pos) >= size) r.st = ST_RANGE;
                else r.rd = list_vals[pos];
            end
            KIND_WRITE: begin
                if (int'(pos) >= size) r.st = ST_RANGE;
                else list_vals[pos] = val;
            end
            KIND_INSERT: begin
                if (full) r.st = ST_FULL;
                else if (int'(pos) > size) r.st = ST_RANGE;
                else list_vals.insert(pos, val);
            end
            KIND_ERASE: begin
                if (size == 0) r.st = ST_EMPTY;
                else if (int'(pos) >= size) r.st = ST_RANGE;
                else begin
                    r.rd = list_vals[pos];
                    list_vals.delete(pos);
                end
            end
            default: ;
        endcase
        r.cnt = IDX_W'(list_vals.size());
        if (list_vals.size() > 0) begin
            r.front = list_vals[0];
            r.back  = list_vals[list_vals.size()-1];
        end
        return r;
    endfunction

    // sender with bursts and gaps; prediction happens on acceptance
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] pos,
                             input logic signed [VALUE_WIDTH-1:0] val, input bit typed,
                             input logic [STATUS_W-1:0] st, input logic [IDX_W-1:0] cnt);
        t_result r;
        int      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        r = apply_request(kind, pos, val);
        if (typed) begin
            r.st  = st;
            r.cnt = cnt;
        end
        if (r.st == ST_FULL) full_hits++;
        if (r.st == ST_RANGE) range_hits++;
        pending_results.insert(pending_results.size(), r);
        words_in++;
        burst_left--;
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_position();
        int size;
        size = list_vals.size();
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom_range(0, 127));
            1: return (size > 0) ? IDX_W'(size - 1) : '0;
            2: return IDX_W'(size);
            default: return IDX_W'($urandom_range(0, size));
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 199);
        if (r < 36) return KIND_PUSH_BACK;
        if (r < 60) return KIND_PUSH_FRONT;
        if (r < 78) return KIND_POP_BACK;
        if (r < 94) return KIND_POP_FRONT;
        if (r < 96) return KIND_CLEAR;
        if (r < 120) return KIND_READ;
        if (r < 140) return KIND_WRITE;
        if (r < 168) return KIND_INSERT;
        if (r < 192) return KIND_ERASE;
        return KIND_W'($urandom_range(9, 15));
    endfunction

    initial begin
        t_row plan[22];
        int   k;
        plan = '{
            '{KIND_POP_BACK,   7'd0,   32'sd0,       1'b1, ST_EMPTY, 7'd0},
            '{KIND_POP_FRONT,  7'd0,   32'sd0,       1'b1, ST_EMPTY, 7'd0},
            '{KIND_ERASE,      7'd0,   32'sd0,       1'b1, ST_EMPTY, 7'd0},
            '{KIND_READ,       7'd0,   32'sd0,       1'b1, ST_RANGE, 7'd0},
            '{KIND_WRITE,      7'd0,   32'sd5,       1'b1, ST_RANGE, 7'd0},
            '{KIND_INSERT,     7'd1,   32'sd5,       1'b1, ST_RANGE, 7'd0},
            '{KIND_INSERT,     7'd0,   32'sh80000000, 1'b1, ST_OK,   7'd1},
            '{KIND_PUSH_BACK,  7'd0,   32'sh7fffffff, 1'b1, ST_OK,   7'd2},
            '{KIND_PUSH_FRONT, 7'd127, -32'sd1,      1'b1, ST_OK,    7'd3},
            '{KIND_READ,       7'd0,   32'sd0,       1'b0, ST_OK,    7'd0},
            '{KIND_READ,       7'd2,   32'sd0,       1'b0, ST_OK,    7'd0},
            '{KIND_READ,       7'd3,   32'sd0,       1'b1, ST_RANGE, 7'd3},
            '{KIND_WRITE,      7'd1,   32'sh55aa55aa, 1'b0, ST_OK,   7'd0},
            '{KIND_INSERT,     7'd3,   32'sh2aaaaaaa, 1'b0, ST_OK,   7'd0},
            '{KIND_INSERT,     7'd127, 32'sd9,       1'b1, ST_RANGE, 7'd4},
            '{KIND_ERASE,      7'd0,   32'sd0,       1'b0, ST_OK,    7'd0},
            '{KIND_ERASE,      7'd64,  32'sd0,       1'b1, ST_RANGE, 7'd3},
            '{KIND_W'(9),      7'd0,   32'sd0,       1'b1, ST_OK,    7'd3},
            '{KIND_W'(15),     7'd127, -32'sd1,      1'b1, ST_OK,    7'd3},
            '{KIND_POP_BACK,   7'd0,   32'sd0,       1'b0, ST_OK,    7'd0},
            '{KIND_CLEAR,      7'd0,   32'sd0,       1'b1, ST_OK,    7'd0},
            '{KIND_POP_FRONT,  7'd0,   32'sd0,       1'b1, ST_EMPTY, 7'd0}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (plan[i])
            send_word(plan[i].kind, plan[i].pos, plan[i].val, plan[i].typed,
                      plan[i].st, plan[i].cnt);
        for (k = 0; k < RAND_WORDS; k++) begin
            // periodic fill run so the full status and long walks are reached
            if (k % 250 == 100) begin
                while (list_vals.size() < CAPACITY)
                    send_word($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_INSERT,
                              pick_position(), pick_value(), 1'b0, ST_OK, '0);
                send_word(KIND_PUSH_BACK, 7'd0, pick_value(), 1'b0, ST_OK, '0);
                send_word(KIND_PUSH_FRONT, 7'd0, pick_value(), 1'b0, ST_OK, '0);
                send_word(KIND_INSERT, 7'd127, pick_value(), 1'b0, ST_OK, '0);
                send_word(KIND_READ, 7'd63, 32'sd0, 1'b0, ST_OK, '0);
                send_word(KIND_ERASE, 7'd63, 32'sd0, 1'b0, ST_OK, '0);
            end
            send_word(pick_kind(), pick_position(), pick_value(), 1'b0, ST_OK, '0);
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("run: %0d request words, %0d result words checked", words_in, words_out);
        $display("run: %0d full and %0d bad-position statuses predicted",
                 full_hits, range_hits);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // receiver: changing stall pattern plus one long hold-off
    initial begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (cyc == 3000) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                cyc++;
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    2: i_out_ready <= (cyc % 4 == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
                cyc++;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_read_value, o_entry_count, o_front_value, o_back_value, o_status};
                words_out <= words_out + 1;
                if (pending_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result word %p", got);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("mismatch word %0d: rd %0d/%0d cnt %0d/%0d st %0d/%0d",
                                     words_out, want.rd, got.rd, want.cnt, got.cnt,
                                     want.st, got.st);
                            $display("    front %0d/%0d back %0d/%0d",
                                     want.front, got.front, want.back, got.back);
                        end
                    end
                end
            end
        end
    end

endmodule
